/* rtl/scc_pkg.sv */
// Shared types and constants for the segment cover counter.
package scc_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  localparam int unsigned KeyW     = 32;
  localparam int unsigned CountW   = 9;
  localparam logic [CountW-1:0] CountMax = 9'd511;

  // Input item
  typedef struct packed {
    logic [1:0]             operation;
    logic signed [KeyW-1:0] seg_start;
    logic signed [KeyW-1:0] seg_end;
    logic signed [KeyW-1:0] query_point;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [CountW-1:0] cover_count;
    logic              store_overflowed;
  } out_item_t;

  // Control that travels with an item along the cell row
  typedef struct packed {
    logic vld;
    logic is_query;
    logic ovf;
  } cell_ctl_t;

  // lo carries the segment start or the query point, hi the segment end
  typedef struct packed {
    logic signed [KeyW-1:0] lo;
    logic signed [KeyW-1:0] hi;
  } key_t;

endpackage

/* rtl/segment_cover_counter.sv */
// Top level: segment store as a row of cells, counting covers of a query point.
//
//   channel | dir | handshake                | payload
//   input   | in  | in_valid_i / in_ready_o  | in_i  (operation, seg_start, seg_end, query_point)
//   result  | out | out_valid_o / out_ready_i| out_o (cover_count, store_overflowed)
//
// One item is taken per cycle while the result queue has room.
// Adds and queries walk the row, one cell per cycle while the row is not held;
// a query's result enters the result queue as it leaves the last cell.
// Clears act at once on the fill count and overflow flag and leave the row alone.
// When the two-entry result queue is full the whole row holds and in_ready_o is low.
// Reset clears fill count, overflow flag and item valids; segment slots are not cleared.
module segment_cover_counter #(
  parameter int MAX_SEGMENTS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  scc_pkg::in_item_t   in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output scc_pkg::out_item_t  out_o
);

  localparam int TW  = $clog2(MAX_SEGMENTS + 1);
  localparam int CXW = (TW > scc_pkg::CountW) ? TW : scc_pkg::CountW;

  logic [TW-1:0]      fill_q, fill_d;
  logic               ovf_q, ovf_d;
  logic               q_full, advance, accept, store_full, push;
  scc_pkg::op_e       op;
  scc_pkg::out_item_t push_data;
  logic [CXW-1:0]     cnt_x;

  scc_pkg::cell_ctl_t ctl_w [MAX_SEGMENTS+1];
  scc_pkg::key_t      key_w [MAX_SEGMENTS+1];
  logic [TW-1:0]      tag_w [MAX_SEGMENTS+1];
  logic [TW-1:0]      cnt_w [MAX_SEGMENTS+1];

  assign advance    = ~q_full;
  assign in_ready_o = advance;
  assign accept     = in_valid_i & in_ready_o;
  assign op         = scc_pkg::op_e'(in_i.operation);
  assign store_full = (fill_q == TW'(MAX_SEGMENTS));

  always_comb begin
    fill_d          = fill_q;
    ovf_d           = ovf_q;
    ctl_w[0]        = '0;
    ctl_w[0].ovf    = ovf_q;
    key_w[0].lo     = in_i.seg_start;
    key_w[0].hi     = in_i.seg_end;
    tag_w[0]        = fill_q;
    cnt_w[0]        = '0;
    if (accept) begin
      case (op)
        scc_pkg::OP_CLEAR: begin
          fill_d = '0;
          ovf_d  = 1'b0;
        end
        scc_pkg::OP_ADD: begin
          if (store_full) begin
            ovf_d = 1'b1;
          end else begin
            fill_d       = fill_q + TW'(1);
            ctl_w[0].vld = 1'b1;
          end
        end
        scc_pkg::OP_QUERY: begin
          ctl_w[0].vld      = 1'b1;
          ctl_w[0].is_query = 1'b1;
          key_w[0].lo       = in_i.query_point;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      fill_q <= fill_d;
      ovf_q  <= ovf_d;
    end
  end

  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    scc_cell #(
      .TW  (TW),
      .IDX (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (advance),
      .ctl_i  (ctl_w[k]),
      .key_i  (key_w[k]),
      .tag_i  (tag_w[k]),
      .cnt_i  (cnt_w[k]),
      .ctl_o  (ctl_w[k+1]),
      .key_o  (key_w[k+1]),
      .tag_o  (tag_w[k+1]),
      .cnt_o  (cnt_w[k+1])
    );
  end

  // saturate the count to the result field
  assign cnt_x = CXW'(cnt_w[MAX_SEGMENTS]);
  always_comb begin
    push_data.store_overflowed = ctl_w[MAX_SEGMENTS].ovf;
    if (cnt_x > CXW'(scc_pkg::CountMax)) begin
      push_data.cover_count = scc_pkg::CountMax;
    end else begin
      push_data.cover_count = cnt_x[scc_pkg::CountW-1:0];
    end
  end

  assign push = advance & ctl_w[MAX_SEGMENTS].vld & ctl_w[MAX_SEGMENTS].is_query;

  scc_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

`ifndef NO_ASSERTIONS
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= TW'(MAX_SEGMENTS))
    else $error("fill count beyond capacity");

  a_ovf_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> store_full)
    else $error("overflow flag set while store not full");

  a_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == scc_pkg::OP_CLEAR) |=> (fill_q == '0 && !ovf_q))
    else $error("clear did not reset store state");

  a_no_push_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |=> $stable(fill_q) || $past(accept))
    else $error("fill count moved while row stalled");
`endif

endmodule

/* rtl/scc_cell.sv */
// One cell of the row: holds one segment, captures adds, counts for queries.
module scc_cell #(
  parameter int TW  = 9,
  parameter int IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  scc_pkg::cell_ctl_t ctl_i,
  input  scc_pkg::key_t     key_i,
  input  logic [TW-1:0]     tag_i,
  input  logic [TW-1:0]     cnt_i,
  output scc_pkg::cell_ctl_t ctl_o,
  output scc_pkg::key_t     key_o,
  output logic [TW-1:0]     tag_o,
  output logic [TW-1:0]     cnt_o
);

  scc_pkg::key_t      seg_q;
  scc_pkg::cell_ctl_t ctl_q;
  scc_pkg::key_t      key_q;
  logic [TW-1:0]      tag_q;
  logic [TW-1:0]      cnt_q, cnt_d;
  logic               hit, pt_in;

  // add with this slot's index takes the segment
  assign hit = ctl_i.vld & ~ctl_i.is_query & (tag_i == TW'(IDX));

  // only slots below the fill count seen at query entry take part
  assign pt_in = ctl_i.vld & ctl_i.is_query & (TW'(IDX) < tag_i) &
                 (seg_q.lo <= key_i.lo) & (key_i.lo <= seg_q.hi);

  assign cnt_d = cnt_i + TW'(pt_in);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      key_q <= key_i;
      tag_q <= tag_i;
      cnt_q <= cnt_d;
      if (hit) begin
        seg_q <= key_i;
      end
    end
  end

  assign ctl_o = ctl_q;
  assign key_o = key_q;
  assign tag_o = tag_q;
  assign cnt_o = cnt_q;

endmodule

/* rtl/scc_out_queue.sv */
// Two-entry result queue at the end of the cell row.
module scc_out_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  scc_pkg::out_item_t  push_data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output scc_pkg::out_item_t  out_o
);

  scc_pkg::out_item_t ent_q [2];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign pop         = out_valid_o & out_ready_i;
  assign out_o       = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// Testbench for segment_cover_counter: a directed table, then random segment sets and queries.
module tb;

  localparam int SegCap = 256;
  localparam int ItemTarget = 1800;
  localparam int DrainCycles = SegCap + 40;
  localparam int MinKey = int'(32'h8000_0000);
  localparam int MaxKey = int'(32'h7fff_ffff);
  // operation code the block ignores
  localparam logic [1:0] OpIgnored = 2'd3;

  typedef struct {
    scc_pkg::in_item_t  item;
    bit                 fixed;
    scc_pkg::out_item_t want;
  } dir_row_t;

  typedef struct {
    bit                 fixed;
    scc_pkg::out_item_t want;
  } typed_want_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  scc_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_ready;
  scc_pkg::out_item_t out_item;

  // shadow copy of the segment store
  logic signed [scc_pkg::KeyW-1:0] shadow_lo [SegCap];
  logic signed [scc_pkg::KeyW-1:0] shadow_hi [SegCap];
  int unsigned shadow_fill;
  bit          shadow_ovf;

  scc_pkg::out_item_t cover_expect_q [$];
  typed_want_t        typed_want_q [$];
  dir_row_t           dir_rows [$];
  int                 hint_pool [$];

  int unsigned errors;
  int unsigned accepted_items;
  int unsigned queries_checked;
  int unsigned ovf_results;
  int unsigned peak_fill;
  int unsigned burst_left;
  int unsigned rx_left;
  logic [1:0]  rx_mode;

  segment_cover_counter #(
    .MAX_SEGMENTS(SegCap)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_item)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Applies one item to the shadow store; returns 1 when the item yields a result.
  function automatic bit cover_predict(input scc_pkg::in_item_t it,
                                       output scc_pkg::out_item_t res);
    int unsigned hits;
    res  = '0;
    hits = 0;
    case (it.operation)
      scc_pkg::OP_CLEAR: begin
        shadow_fill = 0;
        shadow_ovf  = 1'b0;
        return 1'b0;
      end
      scc_pkg::OP_ADD: begin
        if (shadow_fill < SegCap) begin
          shadow_lo[shadow_fill] = it.seg_start;
          shadow_hi[shadow_fill] = it.seg_end;
          shadow_fill++;
          if (shadow_fill > peak_fill) peak_fill = shadow_fill;
        end else begin
          shadow_ovf = 1'b1;
        end
        return 1'b0;
      end
      scc_pkg::OP_QUERY: begin
        for (int i = 0; i < shadow_fill; i++) begin
          if (shadow_lo[i] <= it.query_point && it.query_point <= shadow_hi[i]) hits++;
        end
        if (hits > scc_pkg::CountMax) hits = scc_pkg::CountMax;
        res.cover_count      = hits[scc_pkg::CountW-1:0];
        res.store_overflowed = shadow_ovf;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Result check, then prediction for the item accepted at this edge.
  always @(posedge clk) begin
    scc_pkg::out_item_t want;
    typed_want_t        tag;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (cover_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual count %0d ovf %0b",
                   $time, out_item.cover_count, out_item.store_overflowed);
        end else begin
          want = cover_expect_q.pop_front();
          if (out_item.cover_count !== want.cover_count) begin
            errors++;
            $display("%0t: cover_count: expected %0d, actual %0d",
                     $time, want.cover_count, out_item.cover_count);
          end
          if (out_item.store_overflowed !== want.store_overflowed) begin
            errors++;
            $display("%0t: store_overflowed: expected %0b, actual %0b",
                     $time, want.store_overflowed, out_item.store_overflowed);
          end
          queries_checked++;
          if (want.store_overflowed) ovf_results++;
        end
      end
      if (in_valid && in_ready) begin
        tag = typed_want_q.pop_front();
        accepted_items++;
        if (cover_predict(in_item, want)) begin
          if (tag.fixed) want = tag.want;
          cover_expect_q.push_back(want);
        end
      end
    end
  end

  // Receiver: ready pattern switches between free flow, light, heavy and periodic stalls.
  always @(posedge clk) begin
    if (rst_n) begin
      if (rx_left == 0) begin
        rx_mode = 2'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 80);
      end
      rx_left--;
      case (rx_mode)
        2'd0:    out_ready <= 1'b1;
        2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
        2'd2:    out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ((rx_left % 8) < 2);
      endcase
    end
  end

  // Sender: items go out in bursts with random gaps in between.
  task automatic send_item(input scc_pkg::in_item_t it, input bit fixed,
                           input scc_pkg::out_item_t want);
    int unsigned gap;
    typed_want_t tag;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    tag.fixed = fixed;
    tag.want  = want;
    typed_want_q.push_back(tag);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic dir_row_t mk(input logic [1:0] op, input int a, input int b, input int p,
                                  input bit fixed, input int cnt);
    dir_row_t r;
    r.item.operation   = op;
    r.item.seg_start   = a;
    r.item.seg_end     = b;
    r.item.query_point = p;
    r.fixed            = fixed;
    r.want.cover_count = cnt[scc_pkg::CountW-1:0];
    r.want.store_overflowed = 1'b0;
    return r;
  endfunction

  // Keys cluster near zero and near earlier ends so that segments overlap and points hit edges.
  function automatic int rand_key();
    int base;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return int'($urandom_range(0, 80)) - 40;
      4: begin
        case ($urandom_range(0, 3))
          0:       return MinKey;
          1:       return MaxKey;
          2:       return MinKey + 1;
          default: return MaxKey - 1;
        endcase
      end
      5, 6: return int'($urandom());
      default: begin
        if (hint_pool.size() == 0) return int'($urandom());
        base = hint_pool[$urandom_range(0, hint_pool.size() - 1)];
        return base + int'($urandom_range(0, 2)) - 1;
      end
    endcase
  endfunction

  function automatic scc_pkg::in_item_t rand_item(input logic [1:0] op);
    scc_pkg::in_item_t it;
    int lo;
    int hi;
    lo = rand_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: hi = lo + int'($urandom_range(0, 60));
      7:       hi = lo + int'($urandom() >> 1);
      8:       hi = rand_key();
      default: hi = lo - int'($urandom_range(1, 20));
    endcase
    it.operation   = op;
    it.seg_start   = (op == scc_pkg::OP_ADD) ? lo : int'($urandom());
    it.seg_end     = (op == scc_pkg::OP_ADD) ? hi : int'($urandom());
    it.query_point = (op == scc_pkg::OP_QUERY) ? rand_key() : int'($urandom());
    if (op == scc_pkg::OP_ADD) begin
      hint_pool.push_back(lo);
      hint_pool.push_back(hi);
      while (hint_pool.size() > 64) void'(hint_pool.pop_front());
    end
    return it;
  endfunction

  initial begin
    int unsigned work_items;
    int unsigned adds_left;
    int unsigned tail;
    int unsigned seq_idx;
    int unsigned r;
    bit          big;
    in_valid   = 1'b0;
    in_item    = '0;
    out_ready  = 1'b0;
    rst_n      = 1'b0;
    rx_left    = 0;
    rx_mode    = 2'd0;
    burst_left = 0;
    errors     = 0;
    work_items = 0;
    seq_idx    = 0;

    dir_rows.push_back(mk(scc_pkg::OP_QUERY, 0, 0, 0, 1'b1, 0));
    dir_rows.push_back(mk(OpIgnored, int'($urandom()), int'($urandom()), int'($urandom()),
                          1'b0, 0));
    dir_rows.push_back(mk(scc_pkg::OP_ADD, MinKey, MaxKey, 0, 1'b0, 0));
    dir_rows.push_back(mk(scc_pkg::OP_QUERY, 0, 0, MinKey, 1'b1, 1));
    dir_rows.push_back(mk(scc_pkg::OP_QUERY, 0, 0, MaxKey, 1'b1, 1));
    dir_rows.push_back(mk(scc_pkg::OP_ADD, 5, 5, 0, 1'b0, 0));
    dir_rows.push_back(mk(scc_pkg::OP_QUERY, 0, 0, 5, 1'b1, 2));
    dir_rows.push_back(mk(scc_pkg::OP_QUERY, 0, 0, 4, 1'b1, 1));
    dir_rows.push_back(mk(scc_pkg::OP_QUERY, 0, 0, 6, 1'b0, 0));
    // start above end: stored, never counted
    dir_rows.push_back(mk(scc_pkg::OP_ADD, 10, -10, 0, 1'b0, 0));
    dir_rows.push_back(mk(scc_pkg::OP_QUERY, 0, 0, 0, 1'b1, 1));
    dir_rows.push_back(mk(scc_pkg::OP_QUERY, 0, 0, 10, 1'b0, 0));
    dir_rows.push_back(mk(scc_pkg::OP_ADD, -1, 0, 0, 1'b0, 0));
    dir_rows.push_back(mk(scc_pkg::OP_QUERY, 0, 0, -1, 1'b1, 2));
    dir_rows.push_back(mk(scc_pkg::OP_QUERY, 0, 0, 0, 1'b0, 0));
    dir_rows.push_back(mk(scc_pkg::OP_ADD, MaxKey, MaxKey, 0, 1'b0, 0));
    dir_rows.push_back(mk(scc_pkg::OP_QUERY, 0, 0, MaxKey, 1'b1, 2));
    dir_rows.push_back(mk(scc_pkg::OP_ADD, MinKey, MinKey, 0, 1'b0, 0));
    dir_rows.push_back(mk(scc_pkg::OP_QUERY, 0, 0, MinKey, 1'b1, 2));
    dir_rows.push_back(mk(scc_pkg::OP_ADD, MaxKey, MinKey, 0, 1'b0, 0));
    dir_rows.push_back(mk(scc_pkg::OP_QUERY, 0, 0, 0, 1'b0, 0));
    dir_rows.push_back(mk(scc_pkg::OP_CLEAR, 0, 0, 0, 1'b0, 0));
    dir_rows.push_back(mk(scc_pkg::OP_QUERY, 0, 0, MinKey, 1'b1, 0));
    dir_rows.push_back(mk(scc_pkg::OP_ADD, -7, -7, 0, 1'b0, 0));
    dir_rows.push_back(mk(scc_pkg::OP_QUERY, 0, 0, -7, 1'b1, 1));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);

    // Random part: each set starts with a clear; some sets run past capacity.
    while (work_items < ItemTarget) begin
      big       = (seq_idx == 0) || ($urandom_range(0, 4) == 0);
      adds_left = big ? $urandom_range(250, 275) : $urandom_range(0, 30);
      tail      = $urandom_range(2, 12);
      seq_idx++;
      send_item(rand_item(scc_pkg::OP_CLEAR), 1'b0, '0);
      work_items++;
      while (adds_left > 0 || tail > 0) begin
        r = $urandom_range(0, 99);
        if (adds_left > 0 && r < (big ? 85 : 55)) begin
          send_item(rand_item(scc_pkg::OP_ADD), 1'b0, '0);
          adds_left--;
          work_items++;
        end else if (r < 97) begin
          send_item(rand_item(scc_pkg::OP_QUERY), 1'b0, '0);
          if (adds_left == 0) tail--;
          work_items++;
        end else if (r < 99) begin
          send_item(rand_item(OpIgnored), 1'b0, '0);
        end else begin
          send_item(rand_item(scc_pkg::OP_CLEAR), 1'b0, '0);
          work_items++;
        end
      end
    end
    in_valid <= 1'b0;

    while (cover_expect_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Ran %0d items in %0d segment sets; %0d query results checked, %0d after overflow.",
             accepted_items, seq_idx, queries_checked, ovf_results);
    $display("Store filled up to %0d of %0d entries.", peak_fill, SegCap);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Timeout with %0d results still expected.", cover_expect_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
rtl/scc_pkg.sv
rtl/scc_cell.sv
rtl/scc_out_queue.sv
rtl/segment_cover_counter.sv
test/tb.sv
